@@ src/ljo_pkg.sv @@
// ----------------------------------------------------------------------------
// ljo_pkg
// Shared types and constants for the jet label overlay with YCgCo luma
// replacement: payload structs, register map, divider lane layout.
// ----------------------------------------------------------------------------
`default_nettype none

package ljo_pkg;

  localparam int INTENSITY_BITS_DEF = 16;
  localparam int LABEL_BITS_DEF     = 16;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [1:0] REG_INTENSITY_LIMIT = 2'd0;
  localparam logic [1:0] REG_LABEL_MAX       = 2'd1;
  localparam logic [1:0] REG_COLOR_MAX       = 2'd2;

  localparam logic [15:0] INTENSITY_LIMIT_RESET = 16'd1000;
  localparam logic [15:0] LABEL_MAX_RESET       = 16'd1;
  localparam logic [7:0]  COLOR_MAX_RESET       = 8'd255;

  localparam int QUO_BITS  = 8;
  localparam int NUM_BITS  = 24;
  localparam int LANES     = 3;
  localparam int LANE_GRAY = 0;
  localparam int LANE_G    = 1;
  localparam int LANE_RB   = 2;

  typedef enum logic [1:0] {
    RAMP_ZERO,
    RAMP_FULL,
    RAMP_DIV
  } ramp_mode_t;

  typedef struct packed {
    logic [15:0] intensity_sample;
    logic [15:0] label_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_item_t;

  typedef struct packed {
    logic [15:0] intensity_limit;
    logic [15:0] label_max;
    logic [7:0]  color_max;
  } cfg_t;

  typedef struct packed {
    ramp_mode_t r;
    ramp_mode_t g;
    ramp_mode_t b;
  } modes_t;

  typedef struct packed {
    logic [LANES-1:0][NUM_BITS-1:0] rem;
    logic [LANES-1:0][QUO_BITS-1:0] quo;
    modes_t                         modes;
  } div_lanes_t;

endpackage

`default_nettype wire

@@ src/ljo_front.sv @@
// ----------------------------------------------------------------------------
// ljo_front
// Input clamp, jet ramp numerators and ramp modes, scaling by 255 into
// divider dividends. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ljo_front
  import ljo_pkg::*;
#(
  parameter int INTENSITY_BITS = INTENSITY_BITS_DEF,
  parameter int LABEL_BITS     = LABEL_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output div_lanes_t      out_data
);

  logic        a_valid;
  logic [15:0] a_inten;
  logic [15:0] a_lab;
  logic        b_valid;
  logic [15:0] b_gray;
  logic [15:0] b_g;
  logic [15:0] b_rb;
  modes_t      b_modes;
  logic        c_valid;
  div_lanes_t  c_data;

  logic        c_in_stall;
  logic        b_in_stall;

  logic [15:0]        inten_m;
  logic [15:0]        lab_m;
  logic [15:0]        inten_c;
  logic [15:0]        lab_c;
  logic [17:0]        l4;
  logic [17:0]        m2;
  logic [17:0]        m4;
  logic [17:0]        m18;
  logic [17:0]        g_hi;
  logic [17:0]        g_num;
  logic signed [18:0] r_num;
  logic signed [18:0] b_num;
  logic signed [18:0] m_s;
  modes_t             modes;
  logic [15:0]        rb_num;
  div_lanes_t         c_next;

  assign c_in_stall = c_valid && out_stall;
  assign b_in_stall = b_valid && c_in_stall;
  assign in_stall   = a_valid && b_in_stall;

  // stage a: mask and clamp
  always_comb begin
    inten_m = 16'(in_data.intensity_sample[INTENSITY_BITS-1:0]);
    lab_m   = 16'(in_data.label_value[LABEL_BITS-1:0]);
    inten_c = (inten_m > cfg.intensity_limit) ? cfg.intensity_limit : inten_m;
    lab_c   = (lab_m > cfg.label_max) ? cfg.label_max : lab_m;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
    if (!in_stall) begin
      a_inten <= inten_c;
      a_lab   <= lab_c;
    end
  end

  // stage b: ramp numerators and modes
  always_comb begin
    l4    = {a_lab, 2'b00};
    m2    = {1'b0, cfg.label_max, 1'b0};
    m4    = {cfg.label_max, 2'b00};
    m18   = {2'b00, cfg.label_max};
    m_s   = $signed({3'b000, cfg.label_max});
    g_hi  = m4 - l4;
    g_num = (l4 < g_hi) ? l4 : g_hi;
    r_num = $signed({1'b0, l4}) - $signed({1'b0, m2});
    b_num = $signed({1'b0, m2}) - $signed({1'b0, l4});

    if (a_lab == 16'd0 || r_num <= 19'sd0) begin
      modes.r = RAMP_ZERO;
    end else if (r_num >= m_s) begin
      modes.r = RAMP_FULL;
    end else begin
      modes.r = RAMP_DIV;
    end

    if (a_lab == 16'd0 || b_num <= 19'sd0) begin
      modes.b = RAMP_ZERO;
    end else if (b_num >= m_s) begin
      modes.b = RAMP_FULL;
    end else begin
      modes.b = RAMP_DIV;
    end

    if (a_lab == 16'd0 || g_num == 18'd0) begin
      modes.g = RAMP_ZERO;
    end else if (g_num >= m18) begin
      modes.g = RAMP_FULL;
    end else begin
      modes.g = RAMP_DIV;
    end

    rb_num = (r_num > 19'sd0) ? r_num[15:0] : b_num[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!b_in_stall) begin
      b_valid <= a_valid;
    end
    if (!b_in_stall) begin
      b_gray  <= a_inten;
      b_g     <= g_num[15:0];
      b_rb    <= rb_num;
      b_modes <= modes;
    end
  end

  // stage c: dividends = 255 * numerator
  always_comb begin
    c_next                = '0;
    c_next.rem[LANE_GRAY] = {b_gray, 8'h00} - {8'h00, b_gray};
    c_next.rem[LANE_G]    = {b_g, 8'h00} - {8'h00, b_g};
    c_next.rem[LANE_RB]   = {b_rb, 8'h00} - {8'h00, b_rb};
    c_next.modes          = b_modes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (!c_in_stall) begin
      c_valid <= b_valid;
    end
    if (!c_in_stall) begin
      c_data <= c_next;
    end
  end

  assign out_valid = c_valid;
  assign out_data  = c_data;

endmodule

`default_nettype wire

@@ src/ljo_div.sv @@
// ----------------------------------------------------------------------------
// ljo_div
// Pipelined restoring divider, three lanes, one quotient bit per stage.
// Quotients are known to fit in QUO_BITS bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ljo_div
  import ljo_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [LANES-1:0][15:0]  den,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire div_lanes_t              in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output div_lanes_t                   out_data
);

  logic [QUO_BITS:0] stg_valid;
  logic [QUO_BITS:0] stg_stall;
  div_lanes_t        stg_data [QUO_BITS+1];

  assign stg_valid[0]        = in_valid;
  assign stg_data[0]         = in_data;
  assign in_stall            = stg_stall[0];
  assign stg_stall[QUO_BITS] = out_stall;
  assign out_valid           = stg_valid[QUO_BITS];
  assign out_data            = stg_data[QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    localparam int BIT = QUO_BITS - 1 - k;

    logic       vld;
    div_lanes_t dat;
    div_lanes_t step;
    logic       load;

    always_comb begin
      logic [NUM_BITS-1:0] shifted;
      step = stg_data[k];
      for (int l = 0; l < LANES; l++) begin
        shifted = NUM_BITS'(den[l]) << BIT;
        if (stg_data[k].rem[l] >= shifted) begin
          step.rem[l]      = stg_data[k].rem[l] - shifted;
          step.quo[l][BIT] = 1'b1;
        end else begin
          step.quo[l][BIT] = 1'b0;
        end
      end
    end

    assign load         = !vld || !stg_stall[k+1];
    assign stg_stall[k] = !load;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= 1'b0;
      end else if (load) begin
        vld <= stg_valid[k];
      end
      if (load) begin
        dat <= step;
      end
    end

    assign stg_valid[k+1] = vld;
    assign stg_data[k+1]  = dat;
  end

endmodule

`default_nettype wire

@@ src/ljo_color.sv @@
// ----------------------------------------------------------------------------
// ljo_color
// Jet color assembly, forward offset YCgCo, luma replacement by nonzero gray,
// inverse transform with clamp. Two register stages, the last is the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ljo_color
  import ljo_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire div_lanes_t  in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data
);

  function automatic logic [7:0] ramp_val(input ramp_mode_t mode, input logic [7:0] q);
    logic [7:0] v;
    unique case (mode)
      RAMP_ZERO: v = 8'd0;
      RAMP_FULL: v = 8'd255;
      RAMP_DIV:  v = q;
      default:   v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] clamp_ch(input logic signed [11:0] v,
                                          input logic [7:0] hi);
    logic [7:0] o;
    if (v < 12'sd0) begin
      o = 8'd0;
    end else if (v > $signed({4'b0000, hi})) begin
      o = hi;
    end else begin
      o = v[7:0];
    end
    return o;
  endfunction

  logic               s1_valid;
  logic signed [11:0] s1_y;
  logic signed [11:0] s1_cg;
  logic signed [11:0] s1_co;
  logic               s2_valid;
  out_item_t          s2_data;
  logic               s2_in_stall;

  logic [7:0]         r;
  logic [7:0]         g;
  logic [7:0]         b;
  logic [7:0]         gray;
  logic signed [11:0] h;
  logic signed [11:0] r4;
  logic signed [11:0] b4;
  logic signed [11:0] g2;
  logic signed [11:0] r2;
  logic signed [11:0] b2;
  logic signed [11:0] y;
  logic signed [11:0] cg;
  logic signed [11:0] co;
  logic signed [11:0] cmax_s;
  logic signed [11:0] ro;
  logic signed [11:0] go;
  logic signed [11:0] bo;
  out_item_t          s2_next;

  assign s2_in_stall = s2_valid && out_stall;
  assign in_stall    = s1_valid && s2_in_stall;

  always_comb begin
    r    = ramp_val(in_data.modes.r, in_data.quo[LANE_RB]);
    g    = ramp_val(in_data.modes.g, in_data.quo[LANE_G]);
    b    = ramp_val(in_data.modes.b, in_data.quo[LANE_RB]);
    gray = (cfg.intensity_limit == 16'd0) ? 8'd0 : in_data.quo[LANE_GRAY];
    h    = $signed({5'b00000, cfg.color_max[7:1]});
    r4   = $signed({6'b000000, r[7:2]});
    b4   = $signed({6'b000000, b[7:2]});
    g2   = $signed({5'b00000, g[7:1]});
    r2   = $signed({5'b00000, r[7:1]});
    b2   = $signed({5'b00000, b[7:1]});
    y    = r4 + g2 + b4;
    cg   = h + g2 - r4 - b4;
    co   = h + r2 - b2;
    if (gray != 8'd0) begin
      y = $signed({4'b0000, gray});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_y  <= y;
      s1_cg <= cg;
      s1_co <= co;
    end
  end

  always_comb begin
    cmax_s            = $signed({4'b0000, cfg.color_max});
    ro                = s1_y - s1_cg + s1_co;
    go                = s1_y + s1_cg - $signed({5'b00000, cfg.color_max[7:1]});
    bo                = s1_y - s1_cg - s1_co + cmax_s;
    s2_next.red_out   = clamp_ch(ro, cfg.color_max);
    s2_next.green_out = clamp_ch(go, cfg.color_max);
    s2_next.blue_out  = clamp_ch(bo, cfg.color_max);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_in_stall) begin
      s2_valid <= s1_valid;
    end
    if (!s2_in_stall) begin
      s2_data <= s2_next;
    end
  end

  assign out_valid = s2_valid;
  assign out_data  = s2_data;

  // channels never exceed the configured maximum
  a_chan_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.red_out <= cfg.color_max &&
                   out_data.green_out <= cfg.color_max &&
                   out_data.blue_out <= cfg.color_max))
    else $error("output channel above color maximum");

endmodule

`default_nettype wire

@@ src/label_jet_overlay_ycgco_top.sv @@
// ----------------------------------------------------------------------------
// label_jet_overlay_ycgco_top
// Overlays a jet-colored label map on a scaled gray image by replacing the
// YCgCo luma of the label color with the gray level when it is nonzero.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------
//   in      | input     | in_valid/in_stall  | intensity_sample, label_value
//   out     | output    | out_valid/out_stall| red_out, green_out, blue_out
//   apb     | input     | psel/penable/pready| intensity_limit, label_max,
//           |           |                    | color_max
//
// One pixel per cycle sustained while out_stall stays low. The pipeline is
// three front stages, the 8-stage divider with one quotient bit per stage,
// and two color stages.
// Reset clears every valid bit and loads the register defaults.
// A full stage holds while its successor stalls; empty stages keep filling,
// so bubbles close up and in_stall rises only when every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module label_jet_overlay_ycgco_top
  import ljo_pkg::*;
#(
  parameter int INTENSITY_BITS = INTENSITY_BITS_DEF,
  parameter int LABEL_BITS     = LABEL_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire in_item_t                 in_data,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output out_item_t                     out_data,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  cfg_t                   cfg;
  logic                   cfg_wr;
  logic [1:0]             reg_idx;
  logic [LANES-1:0][15:0] den;

  logic       fr_valid;
  logic       fr_stall;
  div_lanes_t fr_data;
  logic       dv_valid;
  logic       dv_stall;
  div_lanes_t dv_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.intensity_limit <= INTENSITY_LIMIT_RESET;
      cfg.label_max       <= LABEL_MAX_RESET;
      cfg.color_max       <= COLOR_MAX_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_INTENSITY_LIMIT: cfg.intensity_limit <= pwdata[15:0];
        REG_LABEL_MAX:       cfg.label_max       <= pwdata[15:0];
        REG_COLOR_MAX:       cfg.color_max       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_INTENSITY_LIMIT: prdata = CFG_DATA_BITS'(cfg.intensity_limit);
      REG_LABEL_MAX:       prdata = CFG_DATA_BITS'(cfg.label_max);
      REG_COLOR_MAX:       prdata = CFG_DATA_BITS'(cfg.color_max);
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    den            = '0;
    den[LANE_GRAY] = cfg.intensity_limit;
    den[LANE_G]    = cfg.label_max;
    den[LANE_RB]   = cfg.label_max;
  end

  ljo_front #(
    .INTENSITY_BITS (INTENSITY_BITS),
    .LABEL_BITS     (LABEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_stall (fr_stall),
    .out_data  (fr_data)
  );

  ljo_div u_div (
    .clk       (clk),
    .rst       (rst),
    .den       (den),
    .in_valid  (fr_valid),
    .in_stall  (fr_stall),
    .in_data   (fr_data),
    .out_valid (dv_valid),
    .out_stall (dv_stall),
    .out_data  (dv_data)
  );

  ljo_color u_color (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (dv_valid),
    .in_stall  (dv_stall),
    .in_data   (dv_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // an empty output stage lets every stage advance
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output stage");

  a_label_max_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && reg_idx == REG_LABEL_MAX) |=> cfg.label_max == $past(pwdata[15:0]))
    else $error("label max register not updated");

  a_color_max_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && reg_idx == REG_COLOR_MAX) |=> cfg.color_max == $past(pwdata[7:0]))
    else $error("color max register not updated");

endmodule

`default_nettype wire

@@ tb/ljo_overlay_checker.sv @@
// ----------------------------------------------------------------------------
// ljo_overlay_checker
// Watches the pixel, color and register ports of the jet label overlay.
// Keeps its own copy of the three registers from observed APB writes,
// computes the expected overlay color for every accepted input pixel and
// compares each accepted output transfer, field by field, with the oldest
// pending color. Reports the failure count and the pending color count.
// ----------------------------------------------------------------------------
module ljo_overlay_checker
  import ljo_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic                     in_stall,
  input  in_item_t                      in_data,
  input  wire logic                     out_valid,
  input  wire logic                     out_stall,
  input  out_item_t                     out_data,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic                     pready,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output int                            fail_count,
  output int                            pending
);

  localparam int MAX_REPORTS = 10;

  cfg_t      cfg_copy;
  out_item_t color_q[$];
  int        fails = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic longint jet_ramp(input longint num, input longint den);
    if (num <= 0) return 0;
    if (num >= den) return 255;
    return (255 * num) / den;
  endfunction

  function automatic logic [7:0] clamp_channel(input longint v, input longint hi);
    longint c;
    c = v;
    if (c < 0) c = 0;
    if (c > hi) c = hi;
    return c[7:0];
  endfunction

  function automatic out_item_t overlay_pixel(input in_item_t px, input cfg_t c);
    longint inten, lab, lim, m, cmax, h, gray, l4, gn, r, g, b, yv, cg, co;
    out_item_t res;
    inten = longint'(px.intensity_sample);
    lab   = longint'(px.label_value);
    lim   = longint'(c.intensity_limit);
    m     = longint'(c.label_max);
    cmax  = longint'(c.color_max);
    h     = cmax / 2;
    gray  = 0;
    r     = 0;
    g     = 0;
    b     = 0;
    if (inten > lim) inten = lim;
    if (lim != 0) gray = (inten * 255) / lim;
    if (lab > m) lab = m;
    if (lab != 0) begin
      l4 = 4 * lab;
      gn = l4;
      if (4 * m - l4 < gn) gn = 4 * m - l4;
      r = jet_ramp(l4 - 2 * m, m);
      g = jet_ramp(gn, m);
      b = jet_ramp(2 * m - l4, m);
    end
    yv = r / 4 + g / 2 + b / 4;
    cg = h + g / 2 - r / 4 - b / 4;
    co = h + r / 2 - b / 2;
    // nonzero gray replaces the luma of the label color
    if (gray != 0) yv = gray;
    res.red_out   = clamp_channel(yv - cg + co, cmax);
    res.green_out = clamp_channel(yv + cg - h, cmax);
    res.blue_out  = clamp_channel(yv - cg - co + cmax, cmax);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      cfg_copy.intensity_limit = INTENSITY_LIMIT_RESET;
      cfg_copy.label_max       = LABEL_MAX_RESET;
      cfg_copy.color_max       = COLOR_MAX_RESET;
      color_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_INTENSITY_LIMIT: cfg_copy.intensity_limit = pwdata[15:0];
          REG_LABEL_MAX:       cfg_copy.label_max       = pwdata[15:0];
          REG_COLOR_MAX:       cfg_copy.color_max       = pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (color_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("unexpected color transfer: r=%0d g=%0d b=%0d",
                     out_data.red_out, out_data.green_out, out_data.blue_out);
        end else begin
          want = color_q.pop_front();
          if (out_data.red_out !== want.red_out || out_data.green_out !== want.green_out ||
              out_data.blue_out !== want.blue_out) begin
            fails++;
            if (fails <= MAX_REPORTS)
              $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.red_out, want.green_out, want.blue_out,
                       out_data.red_out, out_data.green_out, out_data.blue_out);
          end
        end
      end
      if (in_valid && !in_stall) color_q.push_back(overlay_pixel(in_data, cfg_copy));
    end
    fail_count <= fails;
    pending    <= color_q.size();
  end

endmodule

@@ tb/label_jet_overlay_ycgco_top_tb.sv @@
// ----------------------------------------------------------------------------
// label_jet_overlay_ycgco_top_tb
// Drives pixels and register writes into the jet label overlay and gives
// the verdict. A directed pass covers intensity and label extremes, label
// saturation, zero gray, zero limit, zero label max, zero color max and
// an unmapped write; random phases follow under extreme and random register
// settings, with bursty input, a patterned output stall, one long output
// hold-off and one full drain. Checking is done by the overlay checker.
// ----------------------------------------------------------------------------
module label_jet_overlay_ycgco_top_tb;
  import ljo_pkg::*;

  localparam int TIMEOUT_UNITS   = 400000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int HOLD_CYCLES     = 80;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 116;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_UNMAPPED = 4'd12;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     psel      = 1'b0;
  logic                     penable   = 1'b0;
  logic                     pwrite    = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr     = '0;
  logic [CFG_DATA_BITS-1:0] pwdata    = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;
  int                       fail_count;
  int                       pending;
  int                       hold_req_cnt = 0;

  logic [15:0] cur_limit = INTENSITY_LIMIT_RESET;
  logic [15:0] cur_lmax  = LABEL_MAX_RESET;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  label_jet_overlay_ycgco_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  ljo_overlay_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic in_item_t pixel_of(input logic [15:0] inten, input logic [15:0] lab);
    in_item_t px;
    px.intensity_sample = inten;
    px.label_value      = lab;
    return px;
  endfunction

  function automatic in_item_t random_pixel();
    logic [15:0] inten;
    logic [15:0] lab;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: inten = 16'($urandom_range(0, cur_limit));
      6:                inten = 16'(cur_limit + $urandom_range(0, 3));
      default:          inten = 16'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: lab = 16'($urandom_range(0, cur_lmax));
      7:                   lab = 16'(cur_lmax + $urandom_range(0, 3));
      default:             lab = 16'($urandom());
    endcase
    return pixel_of(inten, lab);
  endfunction

  function automatic logic [15:0] pick_max();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(2, 300));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [7:0] pick_cmax();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one pixel transfer; returns in the step of the accepting edge
  task automatic send_pixel(input in_item_t px);
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [15:0] lim, input logic [15:0] lmax,
                                input logic [7:0] cmax);
    logic [CFG_DATA_BITS-1:0] w;
    settle();
    // upper data bits carry noise, the registers keep only their width
    w = $urandom();
    w[15:0] = lim;
    cfg_write({REG_INTENSITY_LIMIT, 2'b00}, w);
    w = $urandom();
    w[15:0] = lmax;
    cfg_write({REG_LABEL_MAX, 2'b00}, w);
    w = $urandom();
    w[7:0] = cmax;
    cfg_write({REG_COLOR_MAX, 2'b00}, w);
    w = $urandom();
    cfg_write(ADDR_UNMAPPED, w);
    cur_limit = lim;
    cur_lmax  = lmax;
  endtask

  // receiver: stall pattern changes in spans, long hold-off on request
  initial begin
    int mode;
    int span_left;
    int cyc;
    int hold_done_cnt;
    mode = 0;
    span_left = 0;
    cyc = 0;
    hold_done_cnt = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req_cnt != hold_done_cnt) begin
        hold_done_cnt++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk) out_stall <= 1'b1;
      end else begin
        if (span_left == 0) begin
          mode = $urandom_range(0, 3);
          span_left = $urandom_range(32, 200);
        end
        span_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((cyc % 5) < 2);
        endcase
      end
    end
  end

  initial begin
    int p;
    int n;
    int k;
    int burst;
    int gap;
    int fast_left;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // register defaults: limit 1000, label max 1
    send_pixel(pixel_of(16'd0, 16'd0));
    send_pixel(pixel_of(16'd999, 16'd1));
    send_pixel(pixel_of(16'd1000, 16'hFFFF));
    send_pixel(pixel_of(16'd1001, 16'd0));
    send_pixel(pixel_of(16'hFFFF, 16'd1));
    send_pixel(pixel_of(16'd1, 16'd1));

    // full ramp sweep with zero gray, then saturated labels
    apply_settings(16'hFFFF, 16'd8, 8'd255);
    for (k = 0; k <= 9; k++) send_pixel(pixel_of(16'd0, k[15:0]));
    send_pixel(pixel_of(16'hFFFF, 16'd4));
    send_pixel(pixel_of(16'h8000, 16'hFFFF));

    // zero intensity limit and zero label max
    apply_settings(16'd0, 16'd0, 8'd128);
    send_pixel(pixel_of(16'd0, 16'd0));
    send_pixel(pixel_of(16'hFFFF, 16'hFFFF));
    send_pixel(pixel_of(16'd1234, 16'd5));

    // zero color max
    apply_settings(16'd1, 16'hFFFF, 8'd0);
    send_pixel(pixel_of(16'd1, 16'hFFFF));
    send_pixel(pixel_of(16'hFFFF, 16'h8000));
    send_pixel(pixel_of(16'd0, 16'h4000));

    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       apply_settings(16'hFFFF, 16'hFFFF, 8'hFF);
        1:       apply_settings(16'd1, 16'd1, 8'd0);
        default: apply_settings(pick_max(), pick_max(), pick_cmax());
      endcase
      n = 0;
      fast_left = 0;
      while (n < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 40);
        for (k = 0; k < burst && n < ITEMS_PER_PHASE; k++) begin
          if (p == 2 && n == 40) begin
            // long receiver hold-off while input keeps coming
            hold_req_cnt <= hold_req_cnt + 1;
            fast_left = 48;
          end
          if (p == 3 && n == 60) begin
            // drain everything before going on
            in_valid <= 1'b0;
            do @(posedge clk); while (pending != 0);
          end
          send_pixel(random_pixel());
          n++;
          if (fast_left > 0) fast_left--;
        end
        gap = (fast_left > 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
src/ljo_pkg.sv
src/ljo_front.sv
src/ljo_div.sv
src/ljo_color.sv
src/label_jet_overlay_ycgco_top.sv
tb/ljo_overlay_checker.sv
tb/label_jet_overlay_ycgco_top_tb.sv
